>>> hdl/lirs_pkg.sv
// shared constants, types and control structs of the linear-interpolation resampler
`timescale 1ns / 1ps
`default_nettype none

package lirs_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RATIO_W  = 19;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned K_W      = 23;
  localparam int unsigned PA_W     = 40;
  localparam int unsigned OC_W     = 26;
  localparam int unsigned N_W      = 4;
  localparam int unsigned PROD_W   = 34;

  // clip and ratio limits
  localparam int unsigned MAX_FRAMES  = 4194304;
  localparam int unsigned OUT_MAX     = 8;
  localparam int unsigned RATIO_ONE   = 65536;
  localparam int unsigned PASS_TOL    = 6;
  localparam int unsigned RATIO_MIN   = 16384;
  localparam int unsigned RATIO_MAX   = 262144;

  // frame-count divider
  localparam int unsigned DIV_W = 40;
  localparam int unsigned DEN_W = 20;
  localparam int unsigned CNT_W = 6;

  // register map: word index taken from paddr[2]
  localparam logic CFG_PITCH_RATIO = 1'b0;

  // which pair of source frames a blend reads
  typedef enum logic [1:0] {
    SRC_HELD = 2'd0,  // frame k-2 to frame k-1
    SRC_SPAN = 2'd1,  // frame k-1 to frame k
    SRC_TAIL = 2'd2   // final frame repeated
  } src_sel_e;

  typedef struct packed {
    logic     accept;     // input transfer taken
    logic     div_start;  // launch output-count division
    logic     mul;        // register blend products
    src_sel_e src_sel;
    logic     emit;       // load output register
    logic     pass;       // emit the frame unchanged
    logic     finish;     // close out this frame
  } cmd_t;

  typedef struct packed {
    logic pass_in;   // ratio sits in the unity window
    logic last_in;   // incoming frame ends the clip
    logic div_busy;
    logic held_go;
    logic span_go;
    logic tail_go;
    logic out_free;
  } stat_t;

endpackage : lirs_pkg

`default_nettype wire

>>> hdl/linear_interp_stereo_resampler_core.sv
// top level of the linear-interpolation stereo resampler with its config register
`timescale 1ns / 1ps
`default_nettype none

// Stereo resampler by linear interpolation. A clip of Q1.15 stereo frames enters one
// transfer at a time on the slave stream, with tlast on its final frame; output frame i
// reads the source at position i * pitch_ratio (unsigned Q16, 0.25 to 4.0, written over
// the APB port at address 0 and clamped to that range) and blends the two neighboring
// source frames, rounding half up. The clip yields round(N / ratio) frames, at least one,
// and the last of them carries tlast. A ratio within 6/65536 of unity passes frames
// through unchanged. The block works on one source frame at a time: a frame is accepted,
// then each output frame it produces takes a blend multiply and then a load of the
// output register, and a closing step ends the frame; in pass-through the accept is
// followed by a single load. Outside pass-through, the final frame of a clip also
// waits for the bit-serial divider that works out the output count. At most 8 outputs
// leave per source frame; output backpressure stretches the emit cycles. The output
// register lets the next source frame be taken while the last result still waits.
// Change the ratio only between frames; it takes effect for the very next step.
module linear_interp_stereo_resampler_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // source stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] left_in, [31:16] right_in
  input  wire logic        s_axis_tlast,   // last_in
  // resampled stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] left_out, [31:16] right_out
  output logic             m_axis_tlast,   // last_out
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lirs_pkg::*;

  logic [RATIO_W-1:0] ratio_q, ratio_d;
  logic [RATIO_W-1:0] wr_val;
  logic               wr_en;
  cmd_t               cmd;
  stat_t              stat;

  // register write: mask to field width, then clamp to the supported range
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == CFG_PITCH_RATIO);
  assign wr_val = pwdata[RATIO_W-1:0];

  always_comb begin
    priority if (wr_val < RATIO_W'(RATIO_MIN)) begin
      ratio_d = RATIO_W'(RATIO_MIN);
    end else if (wr_val > RATIO_W'(RATIO_MAX)) begin
      ratio_d = RATIO_W'(RATIO_MAX);
    end else begin
      ratio_d = wr_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RATIO_W'(RATIO_ONE);
    end else if (wr_en) begin
      ratio_q <= ratio_d;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_PITCH_RATIO) ? 32'(ratio_q) : '0;

  // frame sequencer
  lirs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // clip state, blend arithmetic and output register
  lirs_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ratio_i   (ratio_q),
    .s_data_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast),
    .cmd_i     (cmd),
    .stat_o    (stat)
  );

endmodule : linear_interp_stereo_resampler_core

`default_nettype wire

>>> hdl/lirs_div.sv
// restoring divider, one quotient bit per cycle, for the clip output count
`timescale 1ns / 1ps
`default_nettype none

module lirs_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [lirs_pkg::DIV_W-1:0] num_i,
  input  wire logic [lirs_pkg::DEN_W-1:0] den_i,
  output logic                            busy_o,
  output logic [lirs_pkg::DIV_W-1:0]      quot_o
);
  import lirs_pkg::*;

  logic [DEN_W-1:0] rem_q;
  logic [DIV_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule : lirs_div

`default_nettype wire

>>> hdl/lirs_dpath.sv
// datapath: clip state, phase accumulator, blend multipliers and output register
`timescale 1ns / 1ps
`default_nettype none

module lirs_dpath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [lirs_pkg::RATIO_W-1:0] ratio_i,
  input  wire logic [31:0]                  s_data_i,
  input  wire logic                         s_last_i,
  output logic                              m_valid_o,
  input  wire logic                         m_ready_i,
  output logic [31:0]                       m_data_o,
  output logic                              m_last_o,
  input  wire lirs_pkg::cmd_t               cmd_i,
  output lirs_pkg::stat_t                   stat_o
);
  import lirs_pkg::*;

  // clip state
  logic [K_W-1:0]      k_q;
  logic                have_prev_q;
  logic [PA_W-1:0]     pa_q;
  logic [OC_W-1:0]     oc_q;
  logic [N_W-1:0]      n_q;
  logic                last_q;
  logic [SAMPLE_W-1:0] cur_l_q, cur_r_q, prev_l_q, prev_r_q, old_l_q, old_r_q;

  // blend stage
  logic signed [PROD_W-1:0] prod_l_q, prod_r_q, prod_l_d, prod_r_d;
  logic [SAMPLE_W-1:0]      base_l_q, base_r_q;
  logic [SAMPLE_W-1:0]      a_l, a_r, b_l, b_r;
  logic signed [SAMPLE_W:0] diff_l, diff_r;
  logic signed [FRAC_W:0]   frac_s;
  logic signed [PROD_W-1:0] rnd_l, rnd_r;
  logic [SAMPLE_W-1:0]      out_l, out_r;

  // output register
  logic        m_valid_q;
  logic [31:0] m_data_q;
  logic        m_last_q;
  logic        m_last_d;

  // status helpers
  logic [K_W-1:0]    kp1;
  logic [K_W:0]      pa_hi;
  logic              n_ok;
  logic              oc_done;
  logic [K_W+18:0]   span_lhs, span_rhs;
  logic [DIV_W-1:0]  num;
  logic [DIV_W-1:0]  quot;
  logic [OC_W-1:0]   dst;
  logic              div_busy;

  assign kp1   = k_q + K_W'(1);
  assign pa_hi = pa_q[PA_W-1:FRAC_W];
  assign n_ok  = n_q < N_W'(OUT_MAX);
  assign dst   = (quot[OC_W-1:0] == '0) ? OC_W'(1) : quot[OC_W-1:0];
  assign oc_done = oc_q >= dst;

  // (k+1)/ratio with ratio in Q16, rounded: ((k+1)*2^17 + r) / (2r)
  assign num = DIV_W'({kp1, 17'b0}) + DIV_W'(ratio_i);

  lirs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   ({ratio_i, 1'b0}),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // non-final frames hold back outputs whose rounding could fall past the clip end
  assign span_lhs = (K_W+19)'({pa_q, 1'b0}) + (K_W+19)'(ratio_i);
  assign span_rhs = (K_W+19)'({kp1, 17'b0});

  always_comb begin
    stat_o          = '0;
    stat_o.pass_in  = (ratio_i >= RATIO_W'(RATIO_ONE - PASS_TOL)) &&
                      (ratio_i <= RATIO_W'(RATIO_ONE + PASS_TOL));
    stat_o.last_in  = s_last_i || (k_q >= K_W'(MAX_FRAMES - 1));
    stat_o.div_busy = div_busy;
    stat_o.held_go  = (k_q >= K_W'(2)) && n_ok &&
                      (pa_hi < {1'b0, k_q - K_W'(1)}) && !(last_q && oc_done);
    stat_o.span_go  = have_prev_q && n_ok && (pa_hi < {1'b0, k_q}) &&
                      (last_q ? !oc_done : !(span_lhs > span_rhs));
    stat_o.tail_go  = last_q && n_ok && !oc_done;
    stat_o.out_free = !m_valid_q || m_ready_i;
  end

  // source pair select and products
  always_comb begin
    unique case (cmd_i.src_sel)
      SRC_HELD: begin
        a_l = old_l_q;  a_r = old_r_q;  b_l = prev_l_q; b_r = prev_r_q;
      end
      SRC_SPAN: begin
        a_l = prev_l_q; a_r = prev_r_q; b_l = cur_l_q;  b_r = cur_r_q;
      end
      default: begin
        a_l = cur_l_q;  a_r = cur_r_q;  b_l = cur_l_q;  b_r = cur_r_q;
      end
    endcase
    diff_l   = $signed({b_l[SAMPLE_W-1], b_l}) - $signed({a_l[SAMPLE_W-1], a_l});
    diff_r   = $signed({b_r[SAMPLE_W-1], b_r}) - $signed({a_r[SAMPLE_W-1], a_r});
    frac_s   = $signed({1'b0, pa_q[FRAC_W-1:0]});
    prod_l_d = diff_l * frac_s;
    prod_r_d = diff_r * frac_s;
  end

  // round half up, floor shift; only the low sample bits of the sum matter
  assign rnd_l = prod_l_q + PROD_W'(32768);
  assign rnd_r = prod_r_q + PROD_W'(32768);
  assign out_l = cmd_i.pass ? cur_l_q : base_l_q + rnd_l[31:16];
  assign out_r = cmd_i.pass ? cur_r_q : base_r_q + rnd_r[31:16];
  assign m_last_d = cmd_i.pass ? last_q : (last_q && ((oc_q + OC_W'(1)) == dst));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      have_prev_q <= 1'b0;
      pa_q        <= '0;
      oc_q        <= '0;
      n_q         <= '0;
      last_q      <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        last_q <= stat_o.last_in;
        n_q    <= '0;
      end
      if (cmd_i.emit && !cmd_i.pass) begin
        pa_q <= pa_q + PA_W'(ratio_i);
        oc_q <= oc_q + OC_W'(1);
        n_q  <= n_q + N_W'(1);
      end
      if (cmd_i.finish) begin
        if (last_q) begin
          k_q         <= '0;
          have_prev_q <= 1'b0;
          pa_q        <= '0;
          oc_q        <= '0;
        end else begin
          k_q         <= kp1;
          have_prev_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_l_q <= s_data_i[SAMPLE_W-1:0];
      cur_r_q <= s_data_i[2*SAMPLE_W-1:SAMPLE_W];
    end
    if (cmd_i.mul) begin
      prod_l_q <= prod_l_d;
      prod_r_q <= prod_r_d;
      base_l_q <= a_l;
      base_r_q <= a_r;
    end
    if (cmd_i.finish && !last_q) begin
      old_l_q  <= prev_l_q;
      old_r_q  <= prev_r_q;
      prev_l_q <= cur_l_q;
      prev_r_q <= cur_r_q;
    end
    if (cmd_i.emit) begin
      m_data_q <= {out_r, out_l};
      m_last_q <= m_last_d;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_last_o  = m_last_q;

  // checks
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> stat_o.out_free)
    else $error("output register overwritten while full");

  a_emit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= N_W'(OUT_MAX))
    else $error("more outputs per frame than the cap");

  a_clip_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && last_q) |=> (k_q == '0 && pa_q == '0 && oc_q == '0 && !have_prev_q))
    else $error("clip state not cleared after final frame");

  a_no_emit_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit || cmd_i.mul) |-> !div_busy)
    else $error("blend issued before output count is known");

  a_prev_tracks_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_prev_q == (k_q != '0))
    else $error("previous-frame flag out of step with source index");

endmodule : lirs_dpath

`default_nettype wire

>>> hdl/lirs_ctrl.sv
// controller: sequences accept, count division, blend and emit for one frame
`timescale 1ns / 1ps
`default_nettype none

module lirs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_valid_i,
  output logic                 s_ready_o,
  input  wire lirs_pkg::stat_t stat_i,
  output lirs_pkg::cmd_t       cmd_o
);
  import lirs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   pass_q, pass_d;

  always_comb begin
    state_d   = state_q;
    pass_d    = pass_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          pass_d       = stat_i.pass_in;
          if (stat_i.pass_in) begin
            state_d = ST_EMIT;
          end else if (stat_i.last_in) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // each run stays closed once it stops, so priority order gives run order
        priority if (stat_i.held_go) begin
          cmd_o.mul     = 1'b1;
          cmd_o.src_sel = SRC_HELD;
          state_d       = ST_EMIT;
        end else if (stat_i.span_go) begin
          cmd_o.mul     = 1'b1;
          cmd_o.src_sel = SRC_SPAN;
          state_d       = ST_EMIT;
        end else if (stat_i.tail_go) begin
          cmd_o.mul     = 1'b1;
          cmd_o.src_sel = SRC_TAIL;
          state_d       = ST_EMIT;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.pass = pass_q;
          if (pass_q) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

endmodule : lirs_ctrl

`default_nettype wire
